### rtl/bvb_pkg.sv
package bvb_pkg;

  // table geometry
  localparam int ENTRIES    = 64;
  localparam int TILE_UNITS = 64;

  localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // signed width that holds every footprint edge and every box edge
  localparam int TU_BITS = $clog2(TILE_UNITS + 1);
  localparam int CMP_W   = (11 + TU_BITS + 2 > 19) ? (11 + TU_BITS + 2) : 19;

  // command codes carried on tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [9:0] tile_x;
    logic [9:0] tile_y;
    logic [3:0] width_x;
    logic [3:0] width_y;
  } footprint_t;

  localparam int FP_W = $bits(footprint_t);

  typedef struct packed {
    logic signed [17:0] min_x;
    logic signed [17:0] min_y;
    logic signed [17:0] max_x;
    logic signed [17:0] max_y;
  } box_t;

endpackage

### rtl/bvb_ram.sv
module bvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/bvb_ovl.sv
module bvb_ovl (
  input  bvb_pkg::footprint_t fp_i,
  input  bvb_pkg::box_t       box_i,
  output logic                overlap_o
);
  import bvb_pkg::*;

  localparam logic signed [CMP_W-1:0] TU = CMP_W'(TILE_UNITS);

  logic signed [CMP_W-1:0] tmin_x, tmin_y;
  logic signed [CMP_W-1:0] wx, wy;
  logic signed [CMP_W-1:0] fx0, fy0, fx1, fy1;
  logic signed [CMP_W-1:0] bx0, by0, bx1, by1;

  always_comb begin
    // footprint min tile = centre - width/2, then scale to fine units
    tmin_x = CMP_W'(fp_i.tile_x) - CMP_W'(fp_i.width_x[3:1]);
    tmin_y = CMP_W'(fp_i.tile_y) - CMP_W'(fp_i.width_y[3:1]);
    wx     = CMP_W'(fp_i.width_x);
    wy     = CMP_W'(fp_i.width_y);
    fx0    = tmin_x * TU;
    fy0    = tmin_y * TU;
    fx1    = fx0 + wx * TU - CMP_W'(1);
    fy1    = fy0 + wy * TU - CMP_W'(1);
    bx0    = CMP_W'($signed(box_i.min_x));
    by0    = CMP_W'($signed(box_i.min_y));
    bx1    = CMP_W'($signed(box_i.max_x));
    by1    = CMP_W'($signed(box_i.max_y));
    overlap_o = (bx1 >= fx0) && (by1 >= fy0) && (bx0 <= fx1) && (by0 <= fy1);
  end

endmodule

### rtl/box_vs_building_table_first_hit.sv
// Building footprint table with first-hit box search. A word with tuser = 0
// stores one footprint (index, active, centre tile, widths); a word with
// tuser = 1 runs a query: the inclusive fine-unit box is tested against every
// active entry in ascending index order, and the first overlapping entry other
// than the ignore index is returned. Every input word yields exactly one
// result word (writes return hit = 0, hit_index = -1). A write goes straight
// to the result state; a query result waits for the scan of the table, and
// comes sooner when an early hit stops the scan. The input is ready again
// the cycle after the result is loaded. The scan rate is set
// by the single read port of the footprint RAM, one entry per cycle, feeding
// one shared overlap comparator. The input is not ready while a word is in
// progress; a finished result waits in the output register, so the next word
// can be accepted before the result is taken. Active flags live in
// flip-flops cleared by reset, so the RAM needs no clearing pass.
module box_vs_building_table_first_hit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // s_tdata_i, low bit up: index[6:0], active[7], tile_x[17:8], tile_y[27:18],
  // width_x[31:28], width_y[35:32], box_min_x[53:36], box_min_y[71:54],
  // box_max_x[89:72], box_max_y[107:90], zero pad [111:108]
  input  logic [111:0] s_tdata_i,
  // s_tuser_i: cmd[0] (0 write, 1 query)
  input  logic [0:0]   s_tuser_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // m_tdata_o, low bit up: hit[0], hit_index[7:1], ignored_seen[8],
  // zero pad [15:9]
  output logic [15:0]  m_tdata_o
);
  import bvb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // input word fields
  logic signed [6:0] in_index;
  logic              in_active;
  footprint_t        in_fp;
  box_t              in_box;

  assign in_index      = s_tdata_i[6:0];
  assign in_active     = s_tdata_i[7];
  assign in_fp.tile_x  = s_tdata_i[17:8];
  assign in_fp.tile_y  = s_tdata_i[27:18];
  assign in_fp.width_x = s_tdata_i[31:28];
  assign in_fp.width_y = s_tdata_i[35:32];
  assign in_box.min_x  = s_tdata_i[53:36];
  assign in_box.min_y  = s_tdata_i[71:54];
  assign in_box.max_x  = s_tdata_i[89:72];
  assign in_box.max_y  = s_tdata_i[107:90];

  state_e           state_q;
  logic [CNT_W-1:0] addr_q;      // next entry to read
  logic             cmp_vld_q;   // RAM output holds entry cmp_idx_q
  logic [AW-1:0]    cmp_idx_q;
  logic             cmp_act_q;
  logic             hit_q;
  logic             seen_q;
  logic [AW-1:0]    hidx_q;
  logic             m_valid_q;
  logic [15:0]      m_data_q;

  // query payload, no reset
  box_t             box_q;
  logic             ign_vld_q;
  logic [5:0]       ign_idx_q;

  logic [ENTRIES-1:0] active_q;

  logic       in_acc;
  logic       wr_en;
  logic       in_range;
  logic       issue;
  logic [FP_W-1:0] rd_data;
  footprint_t rd_fp;
  logic       overlap;
  logic       ign_match;
  logic       cand;
  logic       last_cmp;
  logic       out_free;
  logic [6:0] hidx_out;

  assign s_tready_o = (state_q == ST_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign in_range   = !in_index[6] && (32'(in_index[5:0]) < ENTRIES);
  assign wr_en      = in_acc && (s_tuser_i[0] == CMD_WRITE) && in_range;
  assign issue      = (state_q == ST_SCAN) && (addr_q < CNT_W'(ENTRIES));

  bvb_ram #(
    .WIDTH (FP_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(in_index[5:0])),
    .wdata_i (in_fp),
    .re_i    (issue),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_fp = rd_data;

  bvb_ovl u_ovl (
    .fp_i      (rd_fp),
    .box_i     (box_q),
    .overlap_o (overlap)
  );

  assign ign_match = ign_vld_q && (32'(cmp_idx_q) == 32'(ign_idx_q));
  assign cand      = cmp_vld_q && cmp_act_q && overlap;
  assign last_cmp  = cmp_vld_q && (32'(cmp_idx_q) == ENTRIES - 1);
  assign out_free  = !m_valid_q || m_tready_i;
  assign hidx_out  = hit_q ? 7'(hidx_q) : 7'h7f;

  // active flags double as entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (wr_en) begin
      active_q[AW'(in_index[5:0])] <= in_active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      box_q     <= in_box;
      ign_vld_q <= !in_index[6];
      ign_idx_q <= in_index[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      cmp_act_q <= 1'b0;
      hit_q     <= 1'b0;
      seen_q    <= 1'b0;
      hidx_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // output register: load a finished result, else drain on handshake
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            hit_q     <= 1'b0;
            seen_q    <= 1'b0;
            addr_q    <= '0;
            cmp_vld_q <= 1'b0;
            state_q   <= (s_tuser_i[0] == CMD_QUERY) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          // read stage: one RAM read per cycle; a hit drops the read in flight
          cmp_vld_q <= issue && !(cand && !ign_match);
          if (issue) begin
            addr_q    <= addr_q + CNT_W'(1);
            cmp_idx_q <= addr_q[AW-1:0];
            cmp_act_q <= active_q[addr_q[AW-1:0]];
          end
          // compare stage
          if (cand && !ign_match) begin
            hit_q     <= 1'b1;
            hidx_q    <= cmp_idx_q;
            state_q   <= ST_DONE;
          end else begin
            if (cand) begin
              seen_q <= 1'b1;
            end
            if (last_cmp) begin
              state_q   <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_data_q  <= {7'b0, seen_q, hidx_out, hit_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  // a reported hit carries a non-negative index, a miss carries -1
  a_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tdata_o[0]) |-> !m_tdata_o[7])
    else $error("hit with negative index");

  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tdata_o[0]) |-> (m_tdata_o[7:1] == 7'h7f))
    else $error("miss without index -1");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_tuser_i[0] == CMD_WRITE)) |=> (state_q == ST_DONE))
    else $error("write did not go to result");

  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_q <= CNT_W'(ENTRIES))
    else $error("scan address past table");

  a_cmp_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SCAN))
    else $error("compare stage live outside scan");

endmodule
